// ===== hdl/angle_bias_kalman_filter_core_macros.svh =====
// Assertion macros shared by the filter block.
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH
// Checks that an implication holds at every clock edge outside reset.
`define ABKF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Checks that an implication holds in the cycle after its antecedent.
`define ABKF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hdl/abkf_pkg.sv =====
// ----------------------------------------------------------------------------
// abkf_pkg
// Types, constants and arithmetic helpers of the angle and bias filter.
// ----------------------------------------------------------------------------
package abkf_pkg;
   localparam int unsigned DataWidth = 32;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned DivQuotWidth = 34;

   localparam logic [CsrIndexWidth-1:0] CSR_TIME_STEP = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ANGLE_NOISE = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BIAS_NOISE = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MEASURE_NOISE = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_OBS_GAIN = 3'd4;

   localparam logic [31:0] TIME_STEP_RESET = 32'd268435;
   localparam logic [31:0] ANGLE_NOISE_RESET = 32'd268435;
   localparam logic [31:0] BIAS_NOISE_RESET = 32'd1342177;
   localparam logic [31:0] MEASURE_NOISE_RESET = 32'd134217728;
   localparam logic [31:0] OBS_GAIN_RESET = 32'd268435456;
   localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;

   // Operand selectors for the shared multiplier.
   typedef enum logic [3:0] {
      OP_RATE_DT, OP_PD0_DT, OP_PD1_DT, OP_BN_DT, OP_C_P0, OP_C_P2, OP_C_PCT0,
      OP_C_P1, OP_K0_PCT0, OP_K0_T1, OP_K1_PCT0, OP_K1_T1, OP_K0_ERR, OP_K1_ERR
   } mul_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PRED, ST_MUL, ST_STORE, ST_ECHK, ST_DIV0, ST_DIV0W, ST_DIV1,
      ST_DIV1W, ST_FINAL, ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_go;
      logic       store;
      mul_op_type op;
      logic       div_start;
      logic       div_sel;
      logic       zero_gain;
      logic       final_rate;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic e_pos;
      logic div_done;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Rounded Q4.28 product from a registered full product.
   function automatic logic signed [31:0] rnd28(input logic signed [65:0] p);
      logic [65:0] m;
      logic [65:0] r;
      m = p[65] ? -p : p;
      r = (m + 66'd134217728) >> 28;
      return sat32(p[65] ? -$signed(r) : $signed(r));
   endfunction
endpackage

// ===== hdl/abkf_stream_if.sv =====
// ----------------------------------------------------------------------------
// abkf_stream_if
// Valid/ready channel carrying two 32-bit signed fields.
// ----------------------------------------------------------------------------
interface abkf_stream_if;
   logic valid;
   logic ready;
   logic signed [31:0] field0;
   logic signed [31:0] field1;
   modport source (output valid, output field0, output field1, input ready);
   modport sink (input valid, input field0, input field1, output ready);
endinterface

// ===== hdl/abkf_divider.sv =====
// ----------------------------------------------------------------------------
// abkf_divider
// Restoring divider, one quotient bit per cycle, rounded gain result.
// ----------------------------------------------------------------------------
module abkf_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic [34:0]        den,
   output logic               done,
   output logic signed [31:0] quot
);
   import abkf_pkg::*;
   logic [60:0] dvd_ff, dvd_in;
   logic [35:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [34:0] den_ff, den_in;
   logic [35:0] trial;
   logic [31:0] mag;
   logic [60:0] qv;
   logic signed [33:0] qs;

   // The rounding term half the divisor is added to the dividend up front.
   always_comb begin
      mag = num[31] ? 32'(-num) : 32'(num);
      dvd_in = dvd_ff; rem_in = rem_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      neg_in = neg_ff; den_in = den_ff; done_in = 1'b0;
      trial = {rem_ff[34:0], dvd_ff[60]} - {1'b0, den_ff};
      if (start) begin
         dvd_in = ({29'd0, mag} << 28) + 61'(den >> 1);
         rem_in = '0; cnt_in = 6'd61; busy_in = 1'b1; neg_in = num[31]; den_in = den;
      end else if (busy_ff) begin
         if (!trial[35]) begin
            rem_in = trial;
            dvd_in = {dvd_ff[59:0], 1'b1};
         end else begin
            rem_in = {rem_ff[34:0], dvd_ff[60]};
            dvd_in = {dvd_ff[59:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in; rem_ff <= rem_in; neg_ff <= neg_in; den_ff <= den_in;
   end

   always_comb begin
      qv = dvd_ff;
      if (qv > 61'd2147483648) qs = 34'sd2147483648;
      else qs = $signed({1'b0, qv[32:0]});
      if (neg_ff) qs = -qs;
      quot = sat32(66'(qs));
   end
   assign done = done_ff;
endmodule

// ===== hdl/abkf_datapath.sv =====
// ----------------------------------------------------------------------------
// abkf_datapath
// Filter state, configuration registers, shared multiplier and divider.
// ----------------------------------------------------------------------------
module abkf_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data,
   input  logic signed [31:0]     m_angle,
   input  logic signed [31:0]     m_rate,
   input  abkf_pkg::cmd_type      cmd,
   output abkf_pkg::status_type   status,
   output logic signed [31:0]     out_angle,
   output logic signed [31:0]     out_rate
);
   import abkf_pkg::*;
   logic [31:0] dt_ff, qa_ff, qb_ff, rm_ff, c0_ff;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in, p0_ff, p0_in, p1_ff, p1_in;
   logic signed [31:0] p2_ff, p2_in, p3_ff, p3_in, ma_ff, mr_ff, rc_ff, rc_in;
   logic signed [31:0] err_ff, err_in, pd0_ff, pd0_in, pd1_ff, pd1_in;
   logic signed [31:0] pct0_ff, pct0_in, pct1_ff, pct1_in, t1_ff, t1_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, oa_ff, or_ff;
   logic signed [34:0] e_ff, e_in;
   logic signed [65:0] prod_ff;
   logic signed [32:0] ma, mb;
   mul_op_type op_ff;
   logic signed [31:0] r, q;
   logic div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= TIME_STEP_RESET; qa_ff <= ANGLE_NOISE_RESET; qb_ff <= BIAS_NOISE_RESET;
         rm_ff <= MEASURE_NOISE_RESET; c0_ff <= OBS_GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TIME_STEP: dt_ff <= csr_data;
            CSR_ANGLE_NOISE: qa_ff <= csr_data;
            CSR_BIAS_NOISE: qb_ff <= csr_data;
            CSR_MEASURE_NOISE: rm_ff <= csr_data;
            CSR_OBS_GAIN: c0_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      ma = '0; mb = '0;
      case (cmd.op)
         OP_RATE_DT: begin ma = 33'(rc_ff); mb = {1'b0, dt_ff}; end
         OP_PD0_DT: begin ma = 33'(pd0_ff); mb = {1'b0, dt_ff}; end
         OP_PD1_DT: begin ma = 33'(pd1_ff); mb = {1'b0, dt_ff}; end
         OP_BN_DT: begin ma = {1'b0, qb_ff}; mb = {1'b0, dt_ff}; end
         OP_C_P0: begin ma = {1'b0, c0_ff}; mb = 33'(p0_ff); end
         OP_C_P2: begin ma = {1'b0, c0_ff}; mb = 33'(p2_ff); end
         OP_C_PCT0: begin ma = {1'b0, c0_ff}; mb = 33'(pct0_ff); end
         OP_C_P1: begin ma = {1'b0, c0_ff}; mb = 33'(p1_ff); end
         OP_K0_PCT0: begin ma = 33'(k0_ff); mb = 33'(pct0_ff); end
         OP_K0_T1: begin ma = 33'(k0_ff); mb = 33'(t1_ff); end
         OP_K1_PCT0: begin ma = 33'(k1_ff); mb = 33'(pct0_ff); end
         OP_K1_T1: begin ma = 33'(k1_ff); mb = 33'(t1_ff); end
         OP_K0_ERR: begin ma = 33'(k0_ff); mb = 33'(err_ff); end
         OP_K1_ERR: begin ma = 33'(k1_ff); mb = 33'(err_ff); end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_go) begin
         prod_ff <= ma * mb;
         op_ff <= cmd.op;
      end
   end

   abkf_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num(cmd.div_sel ? pct1_ff : pct0_ff), .den(e_ff),
      .done(div_done), .quot(q)
   );

   assign r = rnd28(prod_ff);

   always_comb begin
      ang_in = ang_ff; bias_in = bias_ff; p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff;
      p3_in = p3_ff; rc_in = rc_ff; err_in = err_ff; pd0_in = pd0_ff; pd1_in = pd1_ff;
      pct0_in = pct0_ff; pct1_in = pct1_ff; t1_in = t1_ff; e_in = e_ff;
      k0_in = k0_ff; k1_in = k1_ff;
      if (cmd.load) begin
         rc_in = sat32(66'(m_rate) - 66'(bias_ff));
         pd0_in = sat32(66'($signed({1'b0, qa_ff})) - 66'(p1_ff) - 66'(p2_ff));
         pd1_in = sat32(-66'(p3_ff));
      end
      if (cmd.final_rate) rc_in = sat32(66'(mr_ff) - 66'(bias_ff));
      if (cmd.zero_gain) begin k0_in = '0; k1_in = '0; end
      if (div_done) begin
         if (cmd.div_sel) k1_in = q; else k0_in = q;
      end
      // A store step folds the registered product into its destination.
      if (cmd.store) begin
         case (op_ff)
            OP_RATE_DT: begin
               ang_in = sat32(66'(ang_ff) + 66'(r));
               err_in = sat32(66'(ma_ff) - 66'(ang_in));
            end
            OP_PD0_DT: p0_in = sat32(66'(p0_ff) + 66'(r));
            OP_PD1_DT: begin
               p1_in = sat32(66'(p1_ff) + 66'(r));
               p2_in = sat32(66'(p2_ff) + 66'(r));
            end
            OP_BN_DT: p3_in = sat32(66'(p3_ff) + 66'(r));
            OP_C_P0: pct0_in = r;
            OP_C_P2: pct1_in = r;
            OP_C_PCT0: e_in = 35'($signed({1'b0, rm_ff})) + 35'(r);
            OP_C_P1: t1_in = r;
            OP_K0_PCT0: p0_in = sat32(66'(p0_ff) - 66'(r));
            OP_K0_T1: p1_in = sat32(66'(p1_ff) - 66'(r));
            OP_K1_PCT0: p2_in = sat32(66'(p2_ff) - 66'(r));
            OP_K1_T1: p3_in = sat32(66'(p3_ff) - 66'(r));
            OP_K0_ERR: ang_in = sat32(66'(ang_ff) + 66'(r));
            OP_K1_ERR: bias_in = sat32(66'(bias_ff) + 66'(r));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff <= '0; bias_ff <= '0; p0_ff <= ONE_Q28; p1_ff <= '0; p2_ff <= '0;
         p3_ff <= ONE_Q28;
      end else begin
         ang_ff <= ang_in; bias_ff <= bias_in; p0_ff <= p0_in; p1_ff <= p1_in;
         p2_ff <= p2_in; p3_ff <= p3_in;
      end
      if (cmd.load) begin ma_ff <= m_angle; mr_ff <= m_rate; end
      rc_ff <= rc_in; err_ff <= err_in; pd0_ff <= pd0_in; pd1_ff <= pd1_in;
      pct0_ff <= pct0_in; pct1_ff <= pct1_in; t1_ff <= t1_in; e_ff <= e_in;
      k0_ff <= k0_in; k1_ff <= k1_in;
      // The corrected rate is captured as it is formed in the final step.
      if (cmd.out_load) begin oa_ff <= ang_ff; or_ff <= rc_in; end
   end

   assign status.e_pos = !e_ff[34] && (e_ff != '0);
   assign status.div_done = div_done;
   assign out_angle = oa_ff;
   assign out_rate = or_ff;
endmodule

// ===== hdl/abkf_controller.sv =====
// ----------------------------------------------------------------------------
// abkf_controller
// Sequencer stepping the datapath through predict, gain and update.
// ----------------------------------------------------------------------------
module abkf_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 rsp_fire,
   input  abkf_pkg::status_type status,
   output abkf_pkg::cmd_type    cmd,
   output logic                 req_ready,
   output logic                 rsp_valid
);
   import abkf_pkg::*;
   state_type state_ff, state_in;
   mul_op_type op_ff, op_in;

   // Each multiply has a product state, ST_MUL, followed by a store state, ST_STORE.
   always_comb begin
      state_in = state_ff; op_in = op_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_PRED;
         ST_PRED: begin state_in = ST_MUL; op_in = OP_RATE_DT; end
         ST_MUL: state_in = ST_STORE;
         ST_STORE: begin
            case (op_ff)
               OP_C_PCT0: begin state_in = ST_ECHK; end
               OP_C_P1: begin state_in = ST_MUL; op_in = OP_K0_PCT0; end
               OP_K1_ERR: state_in = ST_FINAL;
               default: begin state_in = ST_MUL; op_in = mul_op_type'(op_ff + 4'd1); end
            endcase
            if (op_ff == OP_C_PCT0) op_in = OP_C_P1;
         end
         ST_ECHK: state_in = status.e_pos ? ST_DIV0 : ST_MUL;
         ST_DIV0: state_in = ST_DIV0W;
         ST_DIV0W: if (status.div_done) state_in = ST_DIV1;
         ST_DIV1: state_in = ST_DIV1W;
         ST_DIV1W: if (status.div_done) state_in = ST_MUL;
         ST_FINAL: state_in = ST_OUT;
         ST_OUT: if (rsp_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.op = op_ff;
      req_ready = 1'b0; rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin req_ready = 1'b1; cmd.load = req_fire; end
         ST_MUL: cmd.mul_go = 1'b1;
         ST_STORE: cmd.store = 1'b1;
         ST_ECHK: cmd.zero_gain = 1'b1;
         ST_DIV0: cmd.div_start = 1'b1;
         ST_DIV0W: cmd.div_sel = 1'b0;
         ST_DIV1: begin cmd.div_start = 1'b1; cmd.div_sel = 1'b1; end
         ST_DIV1W: cmd.div_sel = 1'b1;
         ST_FINAL: begin cmd.final_rate = 1'b1; cmd.out_load = 1'b1; end
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; op_ff <= OP_RATE_DT;
      end else begin
         state_ff <= state_in; op_ff <= op_in;
      end
   end
endmodule

// ===== hdl/angle_bias_kalman_filter_core.sv =====
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core
// Two-state angle and gyro bias filter, one result per sample.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  req     | in        | measured_angle, measured_rate
//  rsp     | out       | filtered_angle, corrected_rate
//  csr     | in        | write enable, index, 32-bit data
//
// A sample runs, transfer to transfer, through the input step, a set-up step,
// seven multiplies, a variance check, two divisions, seven more multiplies (each
// multiply a product and a store step), a final step and a result step. A
// non-positive innovation variance skips the divisions.
// Reset is synchronous and restores the registers and the filter state.
// One sample is in flight; the result holds until its transfer completes.
module angle_bias_kalman_filter_core (
   input  logic        clock,
   input  logic        reset,
   abkf_stream_if.sink   req,
   abkf_stream_if.source rsp,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import abkf_pkg::*;
   `include "angle_bias_kalman_filter_core_macros.svh"
   cmd_type cmd;
   status_type status;
   logic signed [31:0] out_a, out_r;

   abkf_controller u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req.valid && req.ready),
      .rsp_fire(rsp.valid && rsp.ready), .status(status), .cmd(cmd),
      .req_ready(req.ready), .rsp_valid(rsp.valid)
   );

   abkf_datapath u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .m_angle(req.field0), .m_rate(req.field1), .cmd(cmd),
      .status(status), .out_angle(out_a), .out_rate(out_r)
   );

   assign rsp.field0 = out_a;
   assign rsp.field1 = out_r;

   `ABKF_ASSERT_IMPL(a_no_both, clock, reset, rsp.valid, !req.ready, "busy while result waits")
   `ABKF_ASSERT_NEXT(a_accept, clock, reset, req.valid && req.ready, !req.ready, "accept twice")
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the angle and gyro bias filter. A directed table of
// samples is followed by random samples across several register settings.
// Every result transfer is compared with an in-bench predictor of the filter.
// ----------------------------------------------------------------------------
module tb_top;
   import abkf_pkg::*;

   localparam int unsigned WatchdogLimit = 20000;
   localparam int unsigned DrainCycles = 400;

   typedef struct {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
   } sample_type;

   typedef struct {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
      logic               check_typed;
      logic signed [31:0] typed_angle;
      logic signed [31:0] typed_rate;
   } step_row_type;

   logic clock;
   logic reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   abkf_stream_if req_if();
   abkf_stream_if rsp_if();

   angle_bias_kalman_filter_core DUT (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predictor copy of registers and filter state.
   logic [31:0] time_step_q, angle_noise_q, bias_noise_q, measure_noise_q, obs_gain_q;
   logic signed [31:0] angle_est, bias_est;
   logic signed [31:0] cov [4];

   sample_type filtered_q[$];
   int unsigned failures;
   int unsigned idle_cycles;
   bit          sender_bursts, receiver_bursts, long_hold;

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Operands range over [-2^31, 2^32-1]; the product needs up to 64 bits.
   function automatic logic signed [31:0] qmul(input longint a, input longint b);
      logic        neg;
      logic [63:0] ma, mb, m;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb + 64'd134217728) >> 28;
      if (m > 64'd4294967296) m = 64'd4294967296;
      return clamp32(neg ? -longint'(m) : longint'(m));
   endfunction

   function automatic logic signed [31:0] qdiv(input longint num, input longint den);
      logic        neg;
      logic [63:0] mn, q;
      neg = num < 0;
      mn = (neg ? -num : num) << 28;
      q = (mn + (den >> 1)) / den;
      if (q > 64'd2147483648) q = 64'd2147483648;
      return clamp32(neg ? -longint'(q) : longint'(q));
   endfunction

   task automatic filter_reset();
      time_step_q = TIME_STEP_RESET;
      angle_noise_q = ANGLE_NOISE_RESET;
      bias_noise_q = BIAS_NOISE_RESET;
      measure_noise_q = MEASURE_NOISE_RESET;
      obs_gain_q = OBS_GAIN_RESET;
      angle_est = '0;
      bias_est = '0;
      cov[0] = ONE_Q28;
      cov[1] = '0;
      cov[2] = '0;
      cov[3] = ONE_Q28;
   endtask

   function automatic sample_type filter_step(input sample_type s);
      longint dts, c0, e;
      logic signed [31:0] rate_c, err, pd0, pd1, pct0, pct1, t1, k0, k1;
      sample_type r;
      dts = longint'(time_step_q);
      c0 = longint'(obs_gain_q);
      k0 = '0;
      k1 = '0;
      rate_c = clamp32(longint'(s.rate) - bias_est);
      angle_est = clamp32(longint'(angle_est) + qmul(rate_c, dts));
      err = clamp32(longint'(s.angle) - angle_est);
      pd0 = clamp32(longint'(angle_noise_q) - cov[1] - cov[2]);
      pd1 = clamp32(-longint'(cov[3]));
      cov[0] = clamp32(longint'(cov[0]) + qmul(pd0, dts));
      cov[1] = clamp32(longint'(cov[1]) + qmul(pd1, dts));
      cov[2] = clamp32(longint'(cov[2]) + qmul(pd1, dts));
      cov[3] = clamp32(longint'(cov[3]) + qmul(longint'(bias_noise_q), dts));
      pct0 = qmul(c0, cov[0]);
      pct1 = qmul(c0, cov[2]);
      e = longint'(measure_noise_q) + longint'(qmul(c0, pct0));
      if (e > 0) begin
         k0 = qdiv(pct0, e);
         k1 = qdiv(pct1, e);
      end
      t1 = qmul(c0, cov[1]);
      cov[0] = clamp32(longint'(cov[0]) - qmul(k0, pct0));
      cov[1] = clamp32(longint'(cov[1]) - qmul(k0, t1));
      cov[2] = clamp32(longint'(cov[2]) - qmul(k1, pct0));
      cov[3] = clamp32(longint'(cov[3]) - qmul(k1, t1));
      angle_est = clamp32(longint'(angle_est) + qmul(k0, err));
      bias_est = clamp32(longint'(bias_est) + qmul(k1, err));
      r.angle = angle_est;
      r.rate = clamp32(longint'(s.rate) - bias_est);
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      sample_type exp_s;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (filtered_q.size() == 0) begin
            $error("unexpected result transfer: angle %0d rate %0d",
                   rsp_if.field0, rsp_if.field1);
            failures++;
         end else begin
            exp_s = filtered_q.pop_front();
            if (rsp_if.field0 !== exp_s.angle) begin
               $error("filtered_angle expected %0d actual %0d", exp_s.angle, rsp_if.field0);
               failures++;
            end
            if (rsp_if.field1 !== exp_s.rate) begin
               $error("corrected_rate expected %0d actual %0d", exp_s.rate, rsp_if.field1);
               failures++;
            end
         end
      end
   end

   // Receiver: random stall bursts, one long hold to back up the input.
   initial begin
      int unsigned n;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (600) @(negedge clock);
            long_hold = 1'b0;
         end else if (receiver_bursts && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic csr_put(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_TIME_STEP: time_step_q = val;
         CSR_ANGLE_NOISE: angle_noise_q = val;
         CSR_BIAS_NOISE: bias_noise_q = val;
         CSR_MEASURE_NOISE: measure_noise_q = val;
         CSR_OBS_GAIN: obs_gain_q = val;
         default: ;
      endcase
   endtask

   // Offers one sample from the falling edge and returns after its transfer.
   task automatic send_sample(input sample_type s);
      int unsigned n;
      if (sender_bursts && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         n = $urandom_range(1, 14);
         repeat (n) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.field0 <= s.angle;
      req_if.field1 <= s.rate;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      filtered_q.push_back(filter_step(s));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (filtered_q.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_reg(input logic [31:0] typical);
      case ($urandom_range(0, 6))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return $urandom();
         default: return typical + $urandom_range(0, typical);
      endcase
   endfunction

   initial begin
      step_row_type rows[$];
      step_row_type row;
      sample_type s, got;
      int unsigned phase, k;

      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.field0 = '0;
      req_if.field1 = '0;
      failures = 0;
      idle_cycles = 0;
      sender_bursts = 1'b0;
      receiver_bursts = 1'b0;
      long_hold = 1'b0;
      filter_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // After reset a zero sample leaves the estimates at zero.
      rows.push_back('{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0});
      rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 1'b0, 0, 0});
      rows.push_back('{32'sh80000000, 32'sh80000000, 1'b0, 0, 0});
      rows.push_back('{32'sh80000000, 32'sh7fffffff, 1'b0, 0, 0});
      rows.push_back('{32'sh7fffffff, 32'sh80000000, 1'b0, 0, 0});
      rows.push_back('{32'sd65536, -32'sd65536, 1'b0, 0, 0});
      rows.push_back('{-32'sd1, 32'sd1, 1'b0, 0, 0});
      rows.push_back('{32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, 0, 0});
      rows.push_back('{32'shaaaa_aaaa, 32'sh5555_5555, 1'b0, 0, 0});
      foreach (rows[i]) begin
         row = rows[i];
         s.angle = row.angle;
         s.rate = row.rate;
         if (row.check_typed) begin
            got = filter_step(s);
            filter_reset();
            if (got.angle !== row.typed_angle || got.rate !== row.typed_rate) begin
               $error("directed row %0d: predictor gives angle %0d rate %0d", i,
                      got.angle, got.rate);
               failures++;
            end
         end
         send_sample(s);
      end
      wait_drained();

      // Non-positive innovation variance: zero noise and zero observation gain.
      csr_put(CSR_MEASURE_NOISE, 32'h0);
      csr_put(CSR_OBS_GAIN, 32'h0);
      for (k = 0; k < 4; k++) begin
         s.angle = rand_field();
         s.rate = rand_field();
         send_sample(s);
      end
      wait_drained();
      // Large registers above the signed range, and two ignored indices.
      csr_put(CSR_TIME_STEP, 32'hffff_ffff);
      csr_put(CSR_ANGLE_NOISE, 32'hffff_ffff);
      csr_put(CSR_BIAS_NOISE, 32'hffff_ffff);
      csr_put(CSR_MEASURE_NOISE, 32'hffff_ffff);
      csr_put(CSR_OBS_GAIN, 32'hffff_ffff);
      csr_put(3'd5, 32'h0);
      csr_put(3'd7, 32'h1234_5678);
      for (k = 0; k < 6; k++) begin
         s.angle = rand_field();
         s.rate = rand_field();
         send_sample(s);
      end
      wait_drained();

      sender_bursts = 1'b1;
      receiver_bursts = 1'b1;
      for (phase = 0; phase < 7; phase++) begin
         if (phase == 0) begin
            csr_put(CSR_TIME_STEP, TIME_STEP_RESET);
            csr_put(CSR_ANGLE_NOISE, ANGLE_NOISE_RESET);
            csr_put(CSR_BIAS_NOISE, BIAS_NOISE_RESET);
            csr_put(CSR_MEASURE_NOISE, MEASURE_NOISE_RESET);
            csr_put(CSR_OBS_GAIN, OBS_GAIN_RESET);
         end else begin
            csr_put(CSR_TIME_STEP, rand_reg(TIME_STEP_RESET));
            csr_put(CSR_ANGLE_NOISE, rand_reg(ANGLE_NOISE_RESET));
            csr_put(CSR_BIAS_NOISE, rand_reg(BIAS_NOISE_RESET));
            csr_put(CSR_MEASURE_NOISE, rand_reg(MEASURE_NOISE_RESET));
            csr_put(CSR_OBS_GAIN, rand_reg(OBS_GAIN_RESET));
            if ($urandom_range(0, 1)) csr_put(3'($urandom_range(5, 7)), $urandom());
         end
         if (phase == 1) long_hold = 1'b1;
         if (phase == 6) begin
            sender_bursts = 1'b0;
            receiver_bursts = 1'b0;
         end
         for (k = 0; k < 245; k++) begin
            s.angle = rand_field();
            s.rate = rand_field();
            send_sample(s);
         end
         wait_drained();
      end

      if (failures == 0 && filtered_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/abkf_pkg.sv
hdl/abkf_stream_if.sv
hdl/abkf_divider.sv
hdl/abkf_datapath.sv
hdl/abkf_controller.sv
hdl/angle_bias_kalman_filter_core.sv
tb/sv/tb_top.sv
